// File: rtl/mirc_pkg.sv
// ----------------------------------------------------------------------------
// mirc_pkg: shared types and codes for the mixed integer / real compare
// Order codes, operand kinds and the per-stage control struct.
// ----------------------------------------------------------------------------
package mirc_pkg;
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;
  localparam logic [1:0] ORD_UN = 2'd3;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_REAL = 2'd1;

  // decoded classification of one item after stage one
  typedef struct packed {
    logic       done;    // order already settled
    logic [1:0] order;   // settled order (when done)
    logic       swap;    // real on the left: invert final order
    logic       rr;      // real against real
  } ctl_t;
endpackage

// File: rtl/mixed_int_real_compare.sv
// ----------------------------------------------------------------------------
// mixed_int_real_compare: exact three-way compare of integer / real operands
// Streaming wrapper around the three-stage compare core.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out. The core is a three-stage pipeline
// (classify and align, key forming, final compare), and a new item is taken
// every cycle while the output is not stalled. The whole pipeline holds when
// the output is stalled; ready follows the output side, so nothing is lost or
// repeated.
module mixed_int_real_compare (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: left_kind[1:0], left_bits[65:2], right_kind[66], right_bits[130:67]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: order[1:0]
  output logic [7:0]   out_tdata
);
  import mirc_pkg::*;

  logic       adv;
  logic [1:0] order;

  // advance whenever the output register is empty or being drained
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  mirc_core u_core (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_v(in_tvalid),
    .lk(in_tdata[1:0]), .lb(in_tdata[65:2]),
    .rk(in_tdata[66]), .rb(in_tdata[130:67]),
    .out_v(out_tvalid), .out_order(order)
  );

  assign out_tdata = {6'd0, order};

  // a stalled result holds its order
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");
  // non-numeric left gives unordered at the output
  a_un: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1] ##1 in_tready ##1 in_tready
      |=> out_tdata[1:0] == ORD_UN)
    else $error("non-numeric left not unordered");
endmodule

// File: rtl/mirc_core.sv
// ----------------------------------------------------------------------------
// mirc_core: three-stage compare datapath
// Stage 1 classifies and aligns, stage 2 forms keys, stage 3 compares.
// ----------------------------------------------------------------------------
module mirc_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_v,
  input  logic [1:0]  lk,
  input  logic [63:0] lb,
  input  logic        rk,
  input  logic [63:0] rb,
  output logic        out_v,
  output logic [1:0]  out_order
);
  import mirc_pkg::*;

  // stage 1 registers
  logic        v1_r;
  ctl_t        c1_r, c1_nxt;
  logic [63:0] ia_r, ia_nxt;     // integer operand (or left for int/int, rr)
  logic [63:0] ib_r, ib_nxt;     // right integer / real pattern
  logic        sg_r, sg_nxt;     // real sign
  logic [63:0] ip_r, ip_nxt;     // integer part magnitude
  logic        fr_r, fr_nxt;     // fraction flag
  logic        big_r, big_nxt;   // magnitude >= 2^63 (negative real case)
  logic        mn_r, mn_nxt;     // exactly -2^63

  logic [63:0] iv, db;
  logic [10:0] ex;
  logic [51:0] man;
  logic [52:0] sig;
  logic [11:0] sh;
  logic [116:0] wide;

  always_comb begin
    c1_nxt = '0;
    c1_nxt.swap = (lk == KIND_REAL) && !rk;
    c1_nxt.rr = (lk == KIND_REAL) && rk;
    iv = c1_nxt.swap ? rb : lb;
    db = c1_nxt.swap ? lb : rb;
    ia_nxt = iv;
    ib_nxt = rb;
    ex = db[62:52];
    man = db[51:0];
    sig = {(ex != 11'd0), man};
    sg_nxt = db[63];
    ip_nxt = '0;
    fr_nxt = 1'b0;
    big_nxt = 1'b0;
    mn_nxt = 1'b0;
    sh = 12'd0;
    wide = '0;
    if (lk[1]) begin
      c1_nxt.done = 1'b1;
      c1_nxt.order = ORD_UN;
    end else if (lk == KIND_INT && !rk) begin
      c1_nxt.done = 1'b0;
    end else if (c1_nxt.rr) begin
      c1_nxt.done = 1'b0;
    end else if (ex == 11'h7ff) begin
      c1_nxt.done = 1'b1;
      c1_nxt.order = (man != 52'd0) ? ORD_UN : (db[63] ? ORD_GT : ORD_LT);
    end else if (ex >= 11'd1086) begin
      // magnitude at least 2^63
      if (!db[63]) begin
        c1_nxt.done = 1'b1;
        c1_nxt.order = ORD_LT;
      end else begin
        big_nxt = 1'b1;
        mn_nxt = (ex == 11'd1086) && (man == 52'd0);
      end
    end else begin
      // value < 2^63: shift sig into 64.53 fixed point
      sh = 12'd1086 - {1'b0, (ex == 11'd0) ? 11'd1 : ex};  // 1..1085
      if (sh < 12'd117) wide = {sig, 64'd0} >> sh[6:0];
      ip_nxt = wide[116:53];
      fr_nxt = (wide[52:0] != 53'd0) || (sh >= 12'd117 && sig != 53'd0);
    end
  end

  // stage 2: build comparison keys
  logic        v2_r;
  ctl_t        c2_r;
  logic [64:0] ka_r, ka_nxt, kb_r, kb_nxt; // signed 65-bit keys
  logic        fr2_r, big2_r, mn2_r;
  logic [63:0] ra_r, rb2_r;

  always_comb begin
    ka_nxt = {ia_r[63], ia_r};
    if (c1_r.rr) kb_nxt = '0;
    else if (!sg_r) kb_nxt = {1'b0, ip_r};
    else kb_nxt = 65'd0 - {1'b0, ip_r} - {64'd0, fr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      out_v <= v2_r;
    end
  end

  logic intint_nxt, intint_r;
  assign intint_nxt = (lk == KIND_INT) && !rk;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r <= c1_nxt; ia_r <= ia_nxt; ib_r <= ib_nxt; sg_r <= sg_nxt;
      ip_r <= ip_nxt; fr_r <= fr_nxt; big_r <= big_nxt; mn_r <= mn_nxt;
      intint_r <= intint_nxt;
      c2_r <= c1_r; ka_r <= ka_nxt;
      kb_r <= intint_r ? {ib_r[63], ib_r} : kb_nxt;
      fr2_r <= fr_r && !intint_r; big2_r <= big_r; mn2_r <= mn_r;
      ra_r <= ia_r; rb2_r <= ib_r;
    end
  end

  // stage 3 compare
  logic [1:0] ord_nxt;
  logic [1:0] t;
  logic       az, bz, an, bn;
  logic [63:0] am, bm;
  always_comb begin
    t = ORD_EQ;
    am = {1'b0, ra_r[62:0]};
    bm = {1'b0, rb2_r[62:0]};
    az = am == 64'd0;
    bz = bm == 64'd0;
    an = (ra_r[62:52] == 11'h7ff) && (ra_r[51:0] != 52'd0);
    bn = (rb2_r[62:52] == 11'h7ff) && (rb2_r[51:0] != 52'd0);
    if (c2_r.done) t = c2_r.order;
    else if (c2_r.rr) begin
      if (an || bn) t = ORD_UN;
      else if (az && bz) t = ORD_EQ;
      else if (ra_r[63] != rb2_r[63]) t = ra_r[63] ? ORD_LT : ORD_GT;
      else if (am == bm) t = ORD_EQ;
      else t = ((am < bm) ^ ra_r[63]) ? ORD_LT : ORD_GT;
    end else if (big2_r) begin
      t = (mn2_r && ka_r == {1'b1, 1'b1, 63'd0}) ? ORD_EQ : ORD_GT;
    end else if ($signed(ka_r) < $signed(kb_r)) t = ORD_LT;
    else if ($signed(ka_r) > $signed(kb_r)) t = ORD_GT;
    else t = fr2_r ? ORD_LT : ORD_EQ;
    ord_nxt = t;
    // real on the left: the order was formed integer-first, so mirror it
    if (c2_r.swap) begin
      if (t == ORD_LT) ord_nxt = ORD_GT;
      else if (t == ORD_GT) ord_nxt = ORD_LT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_order <= ord_nxt;
  end
endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: mixed integer / real compare
// Drives operand pairs over the input stream, predicts the order of each pair
// (exact integer arithmetic where an integer takes part, real compares for two
// reals) and checks every output transfer in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mirc_pkg::*;

  localparam logic [1:0] KIND_NONNUM = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // tdata: left_kind[1:0], left_bits[65:2], right_kind[66], right_bits[130:67]
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // tdata: order[1:0]
  logic [7:0]   out_tdata;

  logic [1:0]   order_q[$];   // expected order codes, oldest first
  int           n_errors;
  bit           sink_hold;    // long receiver stall requested
  bit           idle_on;      // random idling enabled on both sides

  mixed_int_real_compare dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Order of integer v against the real with pattern db, computed exactly.
  function automatic logic [1:0] int_real_order(logic signed [63:0] v, logic [63:0] db);
    logic                sgn;
    logic [10:0]         ex;
    logic [52:0]         sig;
    int                  e2;
    logic [63:0]         ip;
    logic                frac;
    logic signed [64:0]  fl;
    logic signed [64:0]  vx;
    sgn = db[63];
    ex  = db[62:52];
    sig = (ex != 0) ? {1'b1, db[51:0]} : {1'b0, db[51:0]};
    if (ex == 11'h7ff) begin
      if (db[51:0] != 0) return ORD_UN;
      return sgn ? ORD_GT : ORD_LT;
    end
    e2 = ((ex != 0) ? int'(ex) : 1) - 1075;
    if (e2 >= 11) begin
      if (!sgn) return ORD_LT;
      if (sig == 53'h10000000000000 && e2 == 11)
        return (v == 64'sh8000000000000000) ? ORD_EQ : ORD_GT;
      return ORD_GT;
    end
    if (e2 >= 0) begin
      ip = 64'(sig) << e2;
      frac = 1'b0;
    end else if (-e2 >= 64) begin
      ip = 0;
      frac = (sig != 0);
    end else begin
      ip = 64'(sig) >> (-e2);
      frac = ((64'(sig) & ((64'd1 << (-e2)) - 1)) != 0);
    end
    fl = sgn ? -$signed({1'b0, ip}) - (frac ? 65'sd1 : 65'sd0) : $signed({1'b0, ip});
    vx = v;
    if (vx < fl) return ORD_LT;
    if (vx > fl) return ORD_GT;
    return frac ? ORD_LT : ORD_EQ;
  endfunction

  function automatic logic [1:0] flip_order(logic [1:0] o);
    if (o == ORD_LT) return ORD_GT;
    if (o == ORD_GT) return ORD_LT;
    return o;
  endfunction

  function automatic logic [1:0] real_real_order(logic [63:0] a, logic [63:0] b);
    real x, y;
    x = $bitstoreal(a);
    y = $bitstoreal(b);
    if (x < y) return ORD_LT;
    if (x > y) return ORD_GT;
    if (x == y) return ORD_EQ;
    return ORD_UN;
  endfunction

  function automatic logic [1:0] predict_order(logic [1:0] lk, logic [63:0] lb,
                                               logic rk, logic [63:0] rb);
    if (lk == KIND_INT) begin
      if (rk == 1'b0) begin
        if ($signed(lb) < $signed(rb)) return ORD_LT;
        if ($signed(lb) > $signed(rb)) return ORD_GT;
        return ORD_EQ;
      end
      return int_real_order(lb, rb);
    end
    if (lk == KIND_REAL)
      return rk ? real_real_order(lb, rb) : flip_order(int_real_order(rb, lb));
    return ORD_UN;
  endfunction

  // Send one pair; hold valid until the transfer happens. Drop valid only
  // while idling, so back-to-back pairs keep it high.
  task automatic send_pair(logic [1:0] lk, logic [63:0] lb, logic rk, logic [63:0] rb);
    while (idle_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, rb, rk, lb, lk};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    order_q = {order_q, predict_order(lk, lb, rk, rb)};
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !sink_hold && !(idle_on && $urandom_range(99) < 25);
    end
  end

  // Check each output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (order_q.size() == 0) begin
        $error("unexpected output transfer, order %0d", out_tdata[1:0]);
        n_errors++;
      end else begin
        logic [1:0] exp_order;
        exp_order = order_q.pop_front();
        if (out_tdata[1:0] !== exp_order) begin
          $error("order: expected %0d, actual %0d", exp_order, out_tdata[1:0]);
          n_errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Doubles biased toward the interesting regions: near 2^63, near integers.
  function automatic logic [63:0] rand_real();
    logic [10:0] ex;
    logic [51:0] man;
    int          lsh;
    case ($urandom_range(5))
      0: ex = 11'h7ff;
      1: ex = 11'd0;
      2: ex = 11'd1086 - 11'($urandom_range(3));
      3: ex = 11'd1023 + 11'($urandom_range(62));
      default: ex = 11'($urandom());
    endcase
    lsh = ($urandom_range(3) == 0) ? int'($urandom_range(52)) : 0;
    man = 52'((rand64() >> 12) << lsh);
    return {1'($urandom()), ex, man};
  endfunction

  // Integer that sometimes matches a double's value exactly.
  function automatic logic [63:0] int_near(logic [63:0] db);
    real x;
    x = $bitstoreal(db);
    if (db[62:52] == 11'h7ff || x >= 9.2e18 || x <= -9.2e18) return rand64();
    return 64'(longint'(x)) + 64'(int'($urandom_range(2)) - 1);
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] pz, nz, pinf, ninf, qnan, m63, one;
    pz = 64'h0; nz = 64'h8000000000000000;
    pinf = 64'h7ff0000000000000; ninf = 64'hfff0000000000000;
    qnan = 64'h7ff8000000000001; m63 = 64'hc3e0000000000000; one = 64'h3ff0000000000000;
    send_pair(KIND_INT, 64'h7fffffffffffffff, 1'b0, 64'h8000000000000000);
    send_pair(KIND_INT, 64'h8000000000000000, 1'b0, 64'h7fffffffffffffff);
    send_pair(KIND_INT, 64'hffffffffffffffff, 1'b0, 64'hffffffffffffffff);
    send_pair(KIND_INT, 64'd0, 1'b1, nz);
    send_pair(KIND_REAL, pz, 1'b1, nz);
    send_pair(KIND_REAL, pz, 1'b0, 64'd0);
    send_pair(KIND_INT, 64'h8000000000000000, 1'b1, m63);
    send_pair(KIND_INT, 64'h8000000000000001, 1'b1, m63);
    send_pair(KIND_REAL, m63, 1'b0, 64'h8000000000000000);
    send_pair(KIND_INT, 64'h7fffffffffffffff, 1'b1, 64'h43e0000000000000);
    send_pair(KIND_INT, 64'h7fffffffffffffff, 1'b1, pinf);
    send_pair(KIND_INT, 64'h8000000000000000, 1'b1, ninf);
    send_pair(KIND_REAL, qnan, 1'b0, 64'd5);
    send_pair(KIND_INT, 64'd5, 1'b1, 64'hfff8000000000000);
    send_pair(KIND_REAL, qnan, 1'b1, qnan);
    send_pair(KIND_REAL, pinf, 1'b1, pinf);
    send_pair(KIND_INT, 64'd1, 1'b1, one);
    send_pair(KIND_INT, 64'hffffffffffffffff, 1'b1, 64'hbff8000000000000);
    send_pair(KIND_INT, 64'hfffffffffffffffe, 1'b1, 64'hbff8000000000000);
    send_pair(KIND_INT, 64'd0, 1'b1, 64'h0000000000000001);
    send_pair(KIND_INT, 64'hffffffffffffffff, 1'b1, 64'h8000000000000001);
    send_pair(KIND_NONNUM, 64'd0, 1'b0, 64'd0);
    send_pair(KIND_UNUSED, 64'hffffffffffffffff, 1'b1, 64'hffffffffffffffff);
  endtask

  task automatic test_random(int count);
    logic [1:0]  lk;
    logic        rk;
    logic [63:0] lb, rb;
    repeat (count) begin
      lk = ($urandom_range(19) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
      rk = 1'($urandom());
      lb = (lk == KIND_REAL) ? rand_real() : rand64();
      rb = rk ? rand_real() : rand64();
      // pull the integer side toward the real one to exercise ties
      if (lk == KIND_INT && rk && $urandom_range(1)) lb = int_near(rb);
      if (lk == KIND_REAL && !rk && $urandom_range(1)) rb = int_near(lb);
      if (lk == {1'b0, rk} && $urandom_range(7) == 0) rb = lb;
      send_pair(lk, lb, rk, rb);
    end
  endtask

  // Stall the receiver while the sender keeps offering, then pause for a drain.
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (60) @(posedge clk);
        sink_hold = 1'b0;
      end
      test_random(40);
    join
    drain();
  endtask

  initial begin
    n_errors   = 0;
    sink_hold  = 1'b0;
    idle_on    = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);        // no idling on this stretch
    idle_on = 1'b1;
    test_directed();
    test_backpressure();
    test_random(1600);
    drain();
    repeat (20) @(posedge clk);
    if (n_errors == 0 && order_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("== FAIL ==");
    $finish;
  end
endmodule
